[hdl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, field widths and request codes for the ordered list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    // Default sizing of the list store
    localparam int MAX_ENTRIES_DEF   = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // Fixed field widths of the item ports
    localparam int KIND_W  = 2;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 7;

    typedef logic [KIND_W-1:0] t_kind;

    // Request codes
    localparam t_kind KIND_CLEAR  = 2'd0;
    localparam t_kind KIND_INSERT = 2'd1;
    localparam t_kind KIND_DELETE = 2'd2;
    localparam t_kind KIND_REMOVE = 2'd3;

    // One request item
    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_request;

    // One result item
    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] removed_value;
        logic [LEN_W-1:0]   removed_count;
        logic [LEN_W-1:0]   new_length;
    } t_result;

endpackage

[hdl/sle_ram.sv]
// ----------------------------------------------------------------------------
// sle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sle_seq.sv]
// ----------------------------------------------------------------------------
// sle_seq
// Request sequencer: checks a request, then streams list entries through the
// RAM one per cycle (read, then write back at the shifted or compacted slot).
// ----------------------------------------------------------------------------
module sle_seq #(
    parameter int MAX_ENTRIES   = sle_pkg::MAX_ENTRIES_DEF,
    parameter int ELEMENT_WIDTH = sle_pkg::ELEMENT_WIDTH_DEF,
    localparam int IW = $clog2(MAX_ENTRIES),
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request side
    input  logic                     i_req_valid,
    input  sle_pkg::t_request        i_req,
    output logic                     o_busy,
    // result side
    output logic                     o_res_valid,
    output sle_pkg::t_result         o_res,
    input  logic                     i_res_take,
    // entry RAM
    output logic                     o_ram_we,
    output logic [IW-1:0]            o_ram_waddr,
    output logic [ELEMENT_WIDTH-1:0] o_ram_wdata,
    output logic                     o_ram_re,
    output logic [IW-1:0]            o_ram_raddr,
    input  logic [ELEMENT_WIDTH-1:0] i_ram_rdata
);

    localparam int EW = ELEMENT_WIDTH;
    // compare width that holds both the position field and count+1
    localparam int PW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]             r_state,    n_state;
    sle_pkg::t_kind         r_kind,     n_kind;
    logic [IW-1:0]          r_pos_idx,  n_pos_idx;
    logic [EW-1:0]          r_val,      n_val;
    logic [CW-1:0]          r_count,    n_count;
    logic [CW-1:0]          r_k,        n_k;
    logic [CW-1:0]          r_left,     n_left;
    logic [IW-1:0]          r_rd_idx,   n_rd_idx;
    logic                   r_pend,     n_pend;
    logic [IW-1:0]          r_pend_idx, n_pend_idx;
    logic [EW-1:0]          r_rv,       n_rv;
    sle_pkg::t_result       r_res,      n_res;

    logic [PW-1:0] w_pos_w;
    logic [PW-1:0] w_cnt_w;
    logic          w_ins_ok;
    logic          w_del_ok;
    logic [CW-1:0] w_span;

    // Position checks against the current length
    assign w_pos_w  = PW'(i_req.position);
    assign w_cnt_w  = PW'(r_count);
    assign w_ins_ok = (w_pos_w != '0) && (w_pos_w <= w_cnt_w + PW'(1))
                      && (r_count != CW'(MAX_ENTRIES));
    assign w_del_ok = (w_pos_w != '0) && (w_pos_w <= w_cnt_w);
    // entries from position to the end of the list: count - pos + 1
    assign w_span   = r_count - CW'(i_req.position) + CW'(1);

    // Next state and RAM control
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_pos_idx  = r_pos_idx;
        n_val      = r_val;
        n_count    = r_count;
        n_k        = r_k;
        n_left     = r_left;
        n_rd_idx   = r_rd_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_rv       = r_rv;
        n_res      = r_res;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_pend_idx;
        o_ram_wdata = i_ram_rdata;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rd_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind    = i_req.kind;
                    n_pos_idx = IW'(i_req.position) - IW'(1);
                    n_val     = EW'($unsigned(i_req.value));
                    n_k       = '0;
                    n_pend    = 1'b0;
                    unique case (i_req.kind)
                        sle_pkg::KIND_CLEAR: begin
                            n_res   = '{ok: 1'b1, removed_value: '0,
                                        removed_count: sle_pkg::LEN_W'(r_count),
                                        new_length: '0};
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        sle_pkg::KIND_INSERT: begin
                            if (w_ins_ok) begin
                                // shift tail up, highest entry first
                                n_left   = w_span;
                                n_rd_idx = IW'(r_count - CW'(1));
                                n_state  = (w_span == '0) ? S_PUT : S_RUN;
                            end else begin
                                n_res   = '{ok: 1'b0, removed_value: '0, removed_count: '0,
                                            new_length: sle_pkg::LEN_W'(r_count)};
                                n_state = S_DONE;
                            end
                        end
                        sle_pkg::KIND_DELETE: begin
                            if (w_del_ok) begin
                                // first read is the victim, the rest shift down
                                n_left   = w_span;
                                n_rd_idx = IW'(i_req.position) - IW'(1);
                                n_state  = S_RUN;
                            end else begin
                                n_res   = '{ok: 1'b0, removed_value: '0, removed_count: '0,
                                            new_length: sle_pkg::LEN_W'(r_count)};
                                n_state = S_DONE;
                            end
                        end
                        sle_pkg::KIND_REMOVE: begin
                            n_left   = r_count;
                            n_rd_idx = '0;
                            if (r_count == '0) begin
                                n_res   = '{ok: 1'b1, removed_value: '0, removed_count: '0,
                                            new_length: '0};
                                n_state = S_DONE;
                            end else begin
                                n_state = S_RUN;
                            end
                        end
                    endcase
                end
            end

            S_RUN: begin
                // issue side: one read per cycle
                if (r_left != '0) begin
                    o_ram_re   = 1'b1;
                    n_left     = r_left - CW'(1);
                    n_rd_idx   = (r_kind == sle_pkg::KIND_INSERT) ? r_rd_idx - IW'(1)
                                                                  : r_rd_idx + IW'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx;
                end else begin
                    n_pend = 1'b0;
                end

                // return side: the write always targets an entry below or above
                // every read still in flight, so no forwarding is needed
                if (r_pend) begin
                    unique case (r_kind)
                        sle_pkg::KIND_INSERT: begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_pend_idx + IW'(1);
                        end
                        sle_pkg::KIND_DELETE: begin
                            if (r_pend_idx == r_pos_idx) begin
                                n_rv = i_ram_rdata;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_pend_idx - IW'(1);
                            end
                        end
                        sle_pkg::KIND_REMOVE: begin
                            if (i_ram_rdata != r_val) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_k[IW-1:0];
                                n_k         = r_k + CW'(1);
                            end
                        end
                        sle_pkg::KIND_CLEAR: begin
                        end
                    endcase

                    // last entry back from the RAM
                    if (r_left == '0) begin
                        unique case (r_kind)
                            sle_pkg::KIND_INSERT: begin
                                n_state = S_PUT;
                            end
                            sle_pkg::KIND_DELETE: begin
                                n_res   = '{ok: 1'b1,
                                            removed_value: sle_pkg::VALUE_W'(n_rv),
                                            removed_count: sle_pkg::LEN_W'(1),
                                            new_length: sle_pkg::LEN_W'(r_count - CW'(1))};
                                n_count = r_count - CW'(1);
                                n_state = S_DONE;
                            end
                            sle_pkg::KIND_REMOVE: begin
                                n_res   = '{ok: 1'b1, removed_value: '0,
                                            removed_count: sle_pkg::LEN_W'(r_count - n_k),
                                            new_length: sle_pkg::LEN_W'(n_k)};
                                n_count = n_k;
                                n_state = S_DONE;
                            end
                            sle_pkg::KIND_CLEAR: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
            end

            S_PUT: begin
                // new value into the opened slot
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pos_idx;
                o_ram_wdata = r_val;
                n_count     = r_count + CW'(1);
                n_res       = '{ok: 1'b1, removed_value: '0, removed_count: '0,
                                new_length: sle_pkg::LEN_W'(r_count + CW'(1))};
                n_state     = S_DONE;
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_pos_idx  <= n_pos_idx;
        r_val      <= n_val;
        r_k        <= n_k;
        r_left     <= n_left;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_rv       <= n_rv;
        r_res      <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

[hdl/sequential_list_engine.sv]
// ----------------------------------------------------------------------------
// sequential_list_engine
// Bounded ordered list store: clear, insert, delete, remove-all-equal.
// ----------------------------------------------------------------------------
// Result: held by the sequencer until the output register takes it, then registered.
// Requests: one at a time; the request channel stalls while an item runs, its
//   run set by the single RAM read port that moves one entry per cycle.
// Reset: list length cleared; entry RAM is not cleared and needs no sweep.
module sequential_list_engine #(
    parameter int MAX_ENTRIES   = sle_pkg::MAX_ENTRIES_DEF,
    parameter int ELEMENT_WIDTH = sle_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [sle_pkg::KIND_W-1:0]          i_kind,
    input  logic [sle_pkg::POS_W-1:0]           i_position,
    input  logic signed [sle_pkg::VALUE_W-1:0]  i_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_ok,
    output logic signed [sle_pkg::VALUE_W-1:0]  o_removed_value,
    output logic [sle_pkg::LEN_W-1:0]           o_removed_count,
    output logic [sle_pkg::LEN_W-1:0]           o_new_length
);

    localparam int IW = $clog2(MAX_ENTRIES);

    sle_pkg::t_request       w_req;
    sle_pkg::t_result        w_res;
    logic                    w_busy;
    logic                    w_res_valid;
    logic                    w_res_take;
    logic                    w_ram_we;
    logic [IW-1:0]           w_ram_waddr;
    logic [ELEMENT_WIDTH-1:0] w_ram_wdata;
    logic                    w_ram_re;
    logic [IW-1:0]           w_ram_raddr;
    logic [ELEMENT_WIDTH-1:0] w_ram_rdata;

    logic                    r_out_valid;
    sle_pkg::t_result        r_out;

    assign w_req = '{kind: i_kind, position: i_position, value: i_value};

    // Sequencer
    sle_seq #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req       (w_req),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    // Entry store
    sle_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output register: loads when empty or being drained
    assign w_res_take = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_stall         = w_busy;
    assign o_valid         = r_out_valid;
    assign o_ok            = r_out.ok;
    assign o_removed_value = r_out.removed_value;
    assign o_removed_count = r_out.removed_count;
    assign o_new_length    = r_out.new_length;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("sequencer took an item but did not go busy");

    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_res_take) |=> (w_res_valid && $stable(w_res)))
        else $error("sequencer result dropped or changed while waiting");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_removed_count == '0 && o_removed_value == '0))
        else $error("failed request reports a removal");

    a_value_only_on_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_removed_value != '0) |-> (o_ok && o_removed_count == 7'd1))
        else $error("removed value without a single-entry delete");

endmodule
